// File: sv/rwp_pkg.sv
// Package for the RGBA window pixel writer.
// Holds the shared types, command codes and blend constants; no dependencies.
package rwp_pkg;

  localparam logic [31:0] SPREAD_MASK  = 32'h07E0_F81F;
  localparam logic [7:0]  CMD_COLUMNS  = 8'h2A;
  localparam logic [7:0]  CMD_ROWS     = 8'h2B;
  localparam logic [7:0]  CMD_WRITE    = 8'h2C;
  localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;

  localparam int unsigned    COUNT_W   = 21;
  localparam logic [20:0]    COUNT_MAX = 21'h1F_FFFF;

  localparam logic [5:0] BITS_CMD   = 6'd8;
  localparam logic [5:0] BITS_PIXEL = 6'd16;
  localparam logic [5:0] BITS_RANGE = 6'd32;

  typedef enum logic {
    KIND_WINDOW = 1'b0,
    KIND_PIXEL  = 1'b1
  } rwp_kind_e;

  typedef enum logic [2:0] {
    BEAT_COL_CMD   = 3'd0,
    BEAT_COL_RANGE = 3'd1,
    BEAT_ROW_CMD   = 3'd2,
    BEAT_ROW_RANGE = 3'd3,
    BEAT_WRITE_CMD = 3'd4
  } rwp_beat_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rwp_pixel_t;

  typedef struct packed {
    logic        is_command;
    logic [31:0] word;
    logic [5:0]  word_bits;
    logic        run_last;
    logic        window_last_pixel;
  } rwp_result_t;

endpackage

// File: sv/rwp_color.sv
// RGBA8888 to RGB565 conversion with alpha blend over the background color.
// Uses rwp_pkg; purely combinational.
module rwp_color (
  input  rwp_pkg::rwp_pixel_t pixel_i,
  input  logic [15:0]         bg_i,
  output logic [15:0]         color_o
);

  logic [15:0] fg;
  logic [8:0]  alpha_sum;
  logic [5:0]  alpha5;
  logic [31:0] fg_spread;
  logic [31:0] bg_spread;
  logic [31:0] diff;
  logic [31:0] prod;
  logic [31:0] mix;

  assign fg = {pixel_i.red[7:3], pixel_i.green[7:2], pixel_i.blue[7:3]};

  assign alpha_sum = {1'b0, pixel_i.alpha} + 9'd4;
  assign alpha5    = alpha_sum[8:3];

  assign fg_spread = {fg, fg} & rwp_pkg::SPREAD_MASK;
  assign bg_spread = {bg_i, bg_i} & rwp_pkg::SPREAD_MASK;
  assign diff      = fg_spread - bg_spread;
  assign prod      = 32'(diff * {26'd0, alpha5});
  assign mix       = ((prod >> 5) + bg_spread) & rwp_pkg::SPREAD_MASK;

  always_comb begin
    if (pixel_i.alpha == rwp_pkg::ALPHA_OPAQUE) begin
      color_o = fg;
    end else if (pixel_i.alpha == rwp_pkg::ALPHA_CLEAR) begin
      color_o = bg_i;
    end else begin
      color_o = mix[31:16] | mix[15:0];
    end
  end

endmodule

// File: sv/rwp_window_words.sv
// Word generator for the five-word window setup sequence and the pixel count.
// Uses rwp_pkg; purely combinational.
module rwp_window_words #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic [COORD_BITS-1:0]    x_i,
  input  logic [COORD_BITS-1:0]    y_i,
  input  logic [COORD_BITS:0]      width_i,
  input  logic [COORD_BITS:0]      height_i,
  input  rwp_pkg::rwp_beat_e       beat_i,
  output rwp_pkg::rwp_result_t     result_o,
  output logic [rwp_pkg::COUNT_W-1:0] count_o
);

  localparam int unsigned PROD_W = 2 * COORD_BITS + 2;

  logic [31:0]       col_word;
  logic [31:0]       row_word;
  logic [15:0]       col_end;
  logic [15:0]       row_end;
  logic [PROD_W-1:0] area;
  logic [63:0]       area_ext;

  assign col_end  = 16'(32'(x_i) + 32'(width_i) - 32'd1);
  assign row_end  = 16'(32'(y_i) + 32'(height_i) - 32'd1);
  assign col_word = {16'(x_i), col_end};
  assign row_word = {16'(y_i), row_end};

  assign area     = PROD_W'(width_i * height_i);
  assign area_ext = 64'(area);
  assign count_o  = (area_ext > 64'(rwp_pkg::COUNT_MAX)) ? rwp_pkg::COUNT_MAX
                                                          : area_ext[rwp_pkg::COUNT_W-1:0];

  always_comb begin
    result_o = '0;
    case (beat_i)
      rwp_pkg::BEAT_COL_CMD: begin
        result_o.is_command = 1'b1;
        result_o.word       = 32'(rwp_pkg::CMD_COLUMNS);
        result_o.word_bits  = rwp_pkg::BITS_CMD;
      end
      rwp_pkg::BEAT_COL_RANGE: begin
        result_o.word      = col_word;
        result_o.word_bits = rwp_pkg::BITS_RANGE;
      end
      rwp_pkg::BEAT_ROW_CMD: begin
        result_o.is_command = 1'b1;
        result_o.word       = 32'(rwp_pkg::CMD_ROWS);
        result_o.word_bits  = rwp_pkg::BITS_CMD;
      end
      rwp_pkg::BEAT_ROW_RANGE: begin
        result_o.word      = row_word;
        result_o.word_bits = rwp_pkg::BITS_RANGE;
      end
      rwp_pkg::BEAT_WRITE_CMD: begin
        result_o.is_command = 1'b1;
        result_o.word       = 32'(rwp_pkg::CMD_WRITE);
        result_o.word_bits  = rwp_pkg::BITS_CMD;
        result_o.run_last   = 1'b1;
      end
      default: begin
        result_o = '0;
      end
    endcase
  end

endmodule

// File: sv/rgba_window_pixel_writer.sv
// Pixel item: a new pixel is accepted every clock while the output is taken;
// each passes through the input register, then the result register.
// Window item: five output words, sent through the single output register, which
// sends one word per clock while the output is taken; s_axis_tready stays low
// until the last word leaves the input register. The pixel count is loaded with
// the window's last word and drops by one per pixel, flagging the window's final
// pixel in m_axis_tuser[1]. The background color register is written directly
// and should only change while no item is in flight.
// Depends on rwp_pkg, rwp_color and rwp_window_words.
module rgba_window_pixel_writer #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic clk_i,
  input  logic rst_ni,

  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // x, y, width, height, red, green, blue, alpha (low to high), zero padded
  input  logic [((4*COORD_BITS+34+7)/8)*8-1:0] s_axis_tdata,
  // kind (0 = window, 1 = pixel)
  input  logic        s_axis_tuser,

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_word, word_bits (low to high), zero padded
  output logic [39:0] m_axis_tdata,
  // is_command, window_last_pixel (low to high)
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned X_LO  = 0;
  localparam int unsigned Y_LO  = C;
  localparam int unsigned W_LO  = 2 * C;
  localparam int unsigned H_LO  = 3 * C + 1;
  localparam int unsigned PX_LO = 4 * C + 2;

  logic [15:0]                  bg_q;
  logic                         v1_q;
  rwp_pkg::rwp_kind_e           kind_q;
  rwp_pkg::rwp_beat_e           beat_q;
  logic [C-1:0]                 x_q;
  logic [C-1:0]                 y_q;
  logic [C:0]                   w_q;
  logic [C:0]                   h_q;
  rwp_pkg::rwp_pixel_t          pixel_q;
  logic [rwp_pkg::COUNT_W-1:0]  left_q;
  logic [rwp_pkg::COUNT_W-1:0]  left_d;
  rwp_pkg::rwp_result_t         res_q;
  rwp_pkg::rwp_result_t         res_d;
  logic                         out_v_q;

  rwp_pkg::rwp_result_t         win_res;
  logic [rwp_pkg::COUNT_W-1:0]  win_count;
  logic [15:0]                  color;
  rwp_pkg::rwp_pixel_t          pixel_in;
  logic                         out_free;
  logic                         issue;
  logic                         last_beat;
  logic                         accept;

  assign pixel_in = {s_axis_tdata[PX_LO +: 8], s_axis_tdata[PX_LO+8 +: 8],
                     s_axis_tdata[PX_LO+16 +: 8], s_axis_tdata[PX_LO+24 +: 8]};

  rwp_window_words #(
    .COORD_BITS(COORD_BITS)
  ) u_window (
    .x_i      (x_q),
    .y_i      (y_q),
    .width_i  (w_q),
    .height_i (h_q),
    .beat_i   (beat_q),
    .result_o (win_res),
    .count_o  (win_count)
  );

  rwp_color u_color (
    .pixel_i (pixel_q),
    .bg_i    (bg_q),
    .color_o (color)
  );

  assign out_free  = !out_v_q || m_axis_tready;
  assign issue     = v1_q && out_free;
  assign last_beat = (kind_q == rwp_pkg::KIND_PIXEL) || (beat_q == rwp_pkg::BEAT_WRITE_CMD);
  assign s_axis_tready = !v1_q || (out_free && last_beat);
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    left_d = left_q;
    if (kind_q == rwp_pkg::KIND_PIXEL) begin
      res_d                   = '0;
      res_d.word              = {16'd0, color};
      res_d.word_bits         = rwp_pkg::BITS_PIXEL;
      res_d.run_last          = 1'b1;
      res_d.window_last_pixel = (left_q == rwp_pkg::COUNT_W'(1));
      if (left_q != '0) begin
        left_d = left_q - rwp_pkg::COUNT_W'(1);
      end
    end else begin
      res_d = win_res;
      if (beat_q == rwp_pkg::BEAT_WRITE_CMD) begin
        left_d = win_count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bg_q    <= '0;
      v1_q    <= 1'b0;
      kind_q  <= rwp_pkg::KIND_WINDOW;
      beat_q  <= rwp_pkg::BEAT_COL_CMD;
      left_q  <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
      if (accept) begin
        v1_q   <= 1'b1;
        kind_q <= rwp_pkg::rwp_kind_e'(s_axis_tuser);
        beat_q <= rwp_pkg::BEAT_COL_CMD;
      end else if (issue && last_beat) begin
        v1_q <= 1'b0;
      end else if (issue) begin
        beat_q <= rwp_pkg::rwp_beat_e'(beat_q + 3'd1);
      end
      if (issue) begin
        left_q  <= left_d;
        out_v_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q     <= s_axis_tdata[X_LO +: C];
      y_q     <= s_axis_tdata[Y_LO +: C];
      w_q     <= s_axis_tdata[W_LO +: C+1];
      h_q     <= s_axis_tdata[H_LO +: C+1];
      pixel_q <= pixel_in;
    end
    if (issue) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, res_q.word_bits, res_q.word};
  assign m_axis_tuser  = {res_q.window_last_pixel, res_q.is_command};
  assign m_axis_tlast  = res_q.run_last;

endmodule
